### hw/rtl/deq_pkg.sv
// Shared types and codes for the bounded deque with insert.
// Holds the request, response and internal command formats.
// No dependencies; every other file imports this package.
package deq_pkg;

   // number of storage slots; the index and fill field widths are sized for it
   localparam int DEPTH   = 16;

   localparam int FUNC_W  = 3;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 4;
   localparam int FILL_W  = 5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4,
      OP_INSERT     = 3'd5,
      OP_NOP        = 3'd6
   } op_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [1:0]               status;
      logic [FILL_W-1:0]        fill;
   } rsp_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
   } cmd_type;

endpackage

### hw/rtl/deq_front.sv
// Front end: accepts requests, decodes the function code into a command
// and holds up to two commands for the back end. Depends on deq_pkg.
module deq_front
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;
   op_type     op_dec;

   always_comb begin
      case (req_data.func)
         OP_PUSH_BACK:  op_dec = OP_PUSH_BACK;
         OP_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
         OP_POP_BACK:   op_dec = OP_POP_BACK;
         OP_POP_FRONT:  op_dec = OP_POP_FRONT;
         OP_READ:       op_dec = OP_READ;
         OP_INSERT:     op_dec = OP_INSERT;
         default:       op_dec = OP_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take      = cmd_take && cmd_valid;

   always_comb begin
      q_in       = '{op: op_dec, value: req_data.value, index: req_data.index};
      wr_ptr_in  = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("command queue count overflow");

endmodule

### hw/rtl/deq_back.sv
// Back end: ring storage, front pointer and fill count, the sequencer that
// carries out commands (including the slot-by-slot shift of an insert)
// and the response register. Depends on deq_pkg.
module deq_back
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_take,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_pop
);

   localparam int AW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);
   localparam int PW = OW + 1;
   localparam int XW = (OW > IDX_W) ? OW : IDX_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SHRD  = 5'b00100,
      S_SHWR  = 5'b01000,
      S_INSWR = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [OW-1:0] pos);
      logic [PW-1:0] s;
      s = PW'(base) + PW'(pos);
      if (s >= PW'(DEPTH)) begin
         s = s - PW'(DEPTH);
      end
      return AW'(s);
   endfunction

   logic [DATA_W-1:0] slots_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [OW-1:0]     occ_ff, occ_in;
   logic [OW-1:0]     k_ff, k_in;
   logic [OW-1:0]     idx1_ff, idx1_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              re, we;
   logic [AW-1:0]     raddr, waddr;
   logic [DATA_W-1:0] wdata;
   logic              start;
   logic              is_full, is_empty, out_of_range;
   logic [OW-1:0]     k_dec;

   assign start        = (state_ff == S_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_pop);
   assign is_full      = (occ_ff == OW'(DEPTH));
   assign is_empty     = (occ_ff == '0);
   assign out_of_range = (XW'(cmd.index) >= XW'(occ_ff));
   assign k_dec        = k_ff - OW'(1);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      k_in         = k_ff;
      idx1_in      = idx1_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      re           = 1'b0;
      we           = 1'b0;
      raddr        = front_ff;
      waddr        = front_ff;
      wdata        = cmd.value;
      cmd_take     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_take     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{data_out: '0, status: ST_OK, fill: FILL_W'(occ_ff)};
               case (cmd.op)
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        we          = 1'b1;
                        waddr       = slot_of(front_ff, occ_ff);
                        occ_in      = occ_ff + OW'(1);
                        rsp_in.fill = FILL_W'(occ_in);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        front_in    = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
                        we          = 1'b1;
                        waddr       = front_in;
                        occ_in      = occ_ff + OW'(1);
                        rsp_in.fill = FILL_W'(occ_in);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        re           = 1'b1;
                        raddr        = slot_of(front_ff, occ_ff - OW'(1));
                        occ_in       = occ_ff - OW'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        re           = 1'b1;
                        raddr        = front_ff;
                        front_in     = slot_of(front_ff, OW'(1));
                        occ_in       = occ_ff - OW'(1);
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  OP_READ: begin
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (out_of_range) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        re           = 1'b1;
                        raddr        = slot_of(front_ff, OW'(cmd.index));
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  OP_INSERT: begin
                     if (is_full) begin
                        rsp_in.status = ST_FULL;
                     end else if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (out_of_range) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        k_in         = occ_ff;
                        idx1_in      = OW'(cmd.index) + OW'(1);
                        val_in       = cmd.value;
                        rsp_valid_in = 1'b0;
                        state_in     = (occ_ff > idx1_in) ? S_SHRD : S_INSWR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{data_out: rd_data_ff, status: ST_OK, fill: FILL_W'(occ_ff)};
            state_in     = S_IDLE;
         end
         S_SHRD: begin
            re       = 1'b1;
            raddr    = slot_of(front_ff, k_dec);
            state_in = S_SHWR;
         end
         S_SHWR: begin
            // move one value a slot toward the back
            we       = 1'b1;
            waddr    = slot_of(front_ff, k_ff);
            wdata    = rd_data_ff;
            k_in     = k_dec;
            state_in = (k_dec > idx1_ff) ? S_SHRD : S_INSWR;
         end
         S_INSWR: begin
            we           = 1'b1;
            waddr        = slot_of(front_ff, idx1_ff);
            wdata        = val_ff;
            occ_in       = occ_ff + OW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = '{data_out: '0, status: ST_OK, fill: FILL_W'(occ_in)};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      idx1_ff <= idx1_in;
      val_ff  <= val_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slots_mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= slots_mem[raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OW'(DEPTH))
      else $error("fill count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response register busy while a command is in flight");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHWR) |-> (k_ff > idx1_ff))
      else $error("insert shift ran past the insert position");

   assert property (@(posedge clock) disable iff (reset) !(re && we))
      else $error("storage read and write in the same cycle");

endmodule

### hw/rtl/bounded_deque_with_insert.sv
// Bounded deque of signed 32-bit values with indexed read and insert-after.
// Each command passes through the front-end queue and then the back-end sequencer; pop and
// read add the S_READ state, and an insert adds S_SHRD and S_SHWR per shifted value, then S_INSWR.
// Push, error and no-op commands are taken at one command per cycle while responses are
// popped; the back end takes no new command until a pop, read or insert is through.
// Reset clears pointers, fill count and queues; stored values are not cleared.
module bounded_deque_with_insert
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;
   logic    rsp_valid;

   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   deq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;

endmodule

### tb/testbench.sv
// Self-checking testbench for bounded_deque_with_insert (needs deq_pkg and the top module).
// Drives queued operations, predicts each response with a software deque and checks
// every field.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int          RANDOM_OPS   = 1400;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          QUIET_START  = 500;
   localparam int          QUIET_END    = 1300;
   localparam logic [2:0]  FUNC_SPARE   = 3'd7;

   typedef struct {
      req_type req;
      bit      drain_first;
   } queued_op_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   queued_op_type pending_ops[$];
   rsp_type       awaiting_rsp[$];
   int            error_count = 0;
   int            cycle_count = 0;

   // software copy of the deque contents
   logic signed [31:0] shadow_slots [DEPTH];
   int                 shadow_front;
   int                 shadow_fill;

   bounded_deque_with_insert u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int slot_at(int pos);
      return (shadow_front + pos) % DEPTH;
   endfunction

   // Apply one operation to the shadow deque and return the response it should give.
   function automatic rsp_type predict_deque_rsp(req_type r);
      rsp_type res;
      bit      is_full;
      bit      is_empty;
      int      k;
      res.data_out = '0;
      res.status   = ST_OK;
      is_full      = shadow_fill >= DEPTH;
      is_empty     = shadow_fill == 0;
      case (r.func)
         OP_PUSH_BACK: begin
            if (is_full) begin
               res.status = ST_FULL;
            end else begin
               shadow_slots[slot_at(shadow_fill)] = r.value;
               shadow_fill++;
            end
         end
         OP_PUSH_FRONT: begin
            if (is_full) begin
               res.status = ST_FULL;
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_slots[shadow_front] = r.value;
               shadow_fill++;
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.data_out = shadow_slots[slot_at(shadow_fill - 1)];
               shadow_fill--;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.data_out = shadow_slots[shadow_front];
               shadow_front = slot_at(1);
               shadow_fill--;
            end
         end
         OP_READ: begin
            if (is_empty) begin
               res.status = ST_EMPTY;
            end else if (int'(r.index) >= shadow_fill) begin
               res.status = ST_RANGE;
            end else begin
               res.data_out = shadow_slots[slot_at(int'(r.index))];
            end
         end
         OP_INSERT: begin
            if (is_full) begin
               res.status = ST_FULL;
            end else if (is_empty) begin
               res.status = ST_EMPTY;
            end else if (int'(r.index) >= shadow_fill) begin
               res.status = ST_RANGE;
            end else begin
               // shift the tail one slot back to open the gap
               for (k = shadow_fill; k > int'(r.index) + 1; k--)
                  shadow_slots[slot_at(k)] = shadow_slots[slot_at(k - 1)];
               shadow_slots[slot_at(int'(r.index) + 1)] = r.value;
               shadow_fill++;
            end
         end
         default: begin
         end
      endcase
      res.fill = shadow_fill[4:0];
      return res;
   endfunction

   task automatic add_op(input logic [2:0] f, input logic signed [31:0] v,
                         input logic [3:0] idx, input bit drain);
      queued_op_type op;
      op.req.func  = f;
      op.req.value = v;
      op.req.index = idx;
      op.drain_first = drain;
      pending_ops.push_back(op);
   endtask

   // Driver: present the head of the pending queue, with random gaps.
   always @(negedge clock) begin : driver
      bit quiet;
      quiet = cycle_count >= QUIET_START && cycle_count < QUIET_END;
      if (reset || pending_ops.size() == 0) begin
         req_push <= 1'b0;
      end else if (pending_ops[0].drain_first && awaiting_rsp.size() != 0) begin
         req_push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 9) begin
         req_push <= 1'b0;
      end else begin
         req_push <= 1'b1;
         req_data <= pending_ops[0].req;
      end
      rsp_pop <= !reset && (quiet || $urandom_range(0, 99) >= 9);
   end

   // Monitor: check each response transfer, then log each request transfer.
   always @(posedge clock) begin : monitor
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (awaiting_rsp.size() == 0) begin
               $error("unexpected response: data_out %0d status %0d fill %0d",
                      rsp_data.data_out, rsp_data.status, rsp_data.fill);
               error_count++;
            end else begin
               want = awaiting_rsp.pop_front();
               if (rsp_data.data_out !== want.data_out) begin
                  $error("data_out: expected %0d, actual %0d", want.data_out,
                         rsp_data.data_out);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.fill !== want.fill) begin
                  $error("fill: expected %0d, actual %0d", want.fill, rsp_data.fill);
                  error_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            awaiting_rsp.push_back(predict_deque_rsp(req_data));
            pending_ops.delete(0);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int                 i;
      int                 r;
      int                 mode;
      int                 w_pb, w_pf, w_ins, w_rd, w_popb, w_popf;
      logic [2:0]         f;
      logic signed [31:0] v;
      logic [3:0]         idx;

      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop  = 1'b0;
      shadow_front = 0;
      shadow_fill  = 0;
      for (i = 0; i < DEPTH; i++)
         shadow_slots[i] = '0;

      // pops, read and insert against an empty deque, plus the no-op and the spare code
      add_op(OP_POP_BACK,  32'sd0, 4'd0, 1'b0);
      add_op(OP_POP_FRONT, 32'sd0, 4'd0, 1'b0);
      add_op(OP_READ,      32'sd0, 4'd0, 1'b0);
      add_op(OP_INSERT,    32'sd5, 4'd0, 1'b0);
      add_op(OP_NOP,       32'sd0, 4'd0, 1'b0);
      add_op(FUNC_SPARE,   -32'sd1, 4'd15, 1'b0);
      // extremes of the value, front pointer wraps below slot zero
      add_op(OP_PUSH_BACK,  32'sh7fffffff, 4'd15, 1'b0);
      add_op(OP_PUSH_FRONT, 32'sh80000000, 4'd0, 1'b0);
      add_op(OP_READ, 32'sd0, 4'd0, 1'b0);
      add_op(OP_READ, 32'sd0, 4'd1, 1'b0);
      add_op(OP_READ, 32'sd0, 4'd2, 1'b0);
      add_op(OP_READ, 32'sd0, 4'd15, 1'b0);
      // insert after the last value appends, then one in the middle
      add_op(OP_INSERT, -32'sd1, 4'd1, 1'b0);
      add_op(OP_INSERT, 32'sd0, 4'd0, 1'b0);
      add_op(OP_INSERT, 32'sd9, 4'd15, 1'b0);
      add_op(OP_READ, 32'sd0, 4'd3, 1'b0);
      add_op(OP_POP_FRONT, 32'sd0, 4'd0, 1'b0);
      add_op(OP_POP_BACK, 32'sd0, 4'd0, 1'b0);
      add_op(OP_NOP, 32'sd0, 4'd0, 1'b0);
      add_op(FUNC_SPARE, 32'sd0, 4'd0, 1'b0);

      // random part: alternate growing, shrinking and balanced stretches
      for (i = 0; i < RANDOM_OPS; i++) begin
         mode = (i / 60) % 3;
         case (mode)
            0: begin
               w_pb = 30; w_pf = 50; w_ins = 65; w_rd = 75; w_popb = 85; w_popf = 95;
            end
            1: begin
               w_pb = 10; w_pf = 20; w_ins = 25; w_rd = 35; w_popb = 65; w_popf = 95;
            end
            default: begin
               w_pb = 17; w_pf = 33; w_ins = 48; w_rd = 63; w_popb = 78; w_popf = 93;
            end
         endcase
         r = $urandom_range(0, 99);
         if (r < w_pb)
            f = OP_PUSH_BACK;
         else if (r < w_pf)
            f = OP_PUSH_FRONT;
         else if (r < w_ins)
            f = OP_INSERT;
         else if (r < w_rd)
            f = OP_READ;
         else if (r < w_popb)
            f = OP_POP_BACK;
         else if (r < w_popf)
            f = OP_POP_FRONT;
         else
            f = r[0] ? OP_NOP : FUNC_SPARE;

         r = $urandom_range(0, 99);
         case (r)
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            2: v = 32'sd0;
            3: v = -32'sd1;
            default: v = $urandom;
         endcase

         if ($urandom_range(0, 99) < 40)
            idx = 4'($urandom_range(0, 3));
         else
            idx = 4'($urandom_range(0, 15));

         add_op(f, v, idx, i == 500 || i == 1000);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || awaiting_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
